// ===== hw/rtl/ucsp_pkg.sv =====
// ----------------------------------------------------------------------------
// ucsp_pkg
// Shared types and constants of the uniform cost shortest path engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ucsp_pkg;

  // default sizes of the node and edge stores
  localparam int unsigned MaxNodesDef = 64;
  localparam int unsigned MaxEdgesDef = 256;

  // field widths
  localparam int unsigned DistW    = 22;
  localparam int unsigned CostW    = 16;
  localparam int unsigned EndW     = 7;
  localparam int unsigned NodeIdxW = 6;
  localparam int unsigned SlotW    = 8;
  localparam int unsigned NodeCntW = 7;
  localparam int unsigned EdgeCntW = 9;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;

  // distance codes
  localparam logic [DistW-1:0] DIST_INF = {DistW{1'b1}};
  localparam logic [DistW-1:0] DIST_SAT = {{(DistW-1){1'b1}}, 1'b0};

  // command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_EDGE_COUNT = 2'd1;

  // input word
  typedef struct packed {
    logic                command;
    logic [SlotW-1:0]    edge_slot;
    logic [EndW-1:0]     edge_from;
    logic [EndW-1:0]     edge_to;
    logic [NodeIdxW-1:0] source_node;
    logic [NodeIdxW-1:0] target_node;
    logic [CostW-1:0]    step_cost;
  } ucsp_in_t;

  // result word
  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             reachable;
  } ucsp_out_t;

  // edge store entry, 1-based endpoints
  typedef struct packed {
    logic [EndW-1:0] from_node;
    logic [EndW-1:0] to_node;
  } ucsp_edge_t;

  // node store entry
  typedef struct packed {
    logic             visited;
    logic [DistW-1:0] node_dist;
  } ucsp_node_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ucsp_ram.sv =====
// ----------------------------------------------------------------------------
// ucsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ucsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ucsp_alu.sv =====
// ----------------------------------------------------------------------------
// ucsp_alu
// Shared distance unit: saturating path sum and one less-than compare.
// ----------------------------------------------------------------------------
`default_nettype none

module ucsp_alu
  import ucsp_pkg::*;
(
  input  wire logic [DistW-1:0] best_i,
  input  wire logic [CostW-1:0] cost_i,
  input  wire logic [DistW-1:0] lhs_i,
  input  wire logic [DistW-1:0] rhs_i,
  output logic      [DistW-1:0] sum_o,
  output logic                  less_o
);

  logic [DistW:0] sum_raw;

  // candidate distance, held below the unreachable code
  assign sum_raw = {1'b0, best_i} + {{(DistW + 1 - CostW){1'b0}}, cost_i};
  assign sum_o   = (sum_raw > {1'b0, DIST_SAT}) ? DIST_SAT : sum_raw[DistW-1:0];

  assign less_o  = lhs_i < rhs_i;

endmodule

`default_nettype wire

// ===== hw/rtl/uniform_cost_shortest_path.sv =====
// ----------------------------------------------------------------------------
// uniform_cost_shortest_path
// Dense Dijkstra engine over a loaded edge list with one step cost for every edge.
// ----------------------------------------------------------------------------
// A load word (command 0) writes one edge into the edge store and gives
// no result. A query word (command 1) runs Dijkstra from source_node and
// returns one result word: distance to target_node and a reachable flag.
// The input side is not ready while a query runs. A query first sweeps the
// node RAM of the nodes in use back to unreached. Each round that picks a
// node then streams the node RAM once for the minimum search and the edge
// RAM once for relaxation; every edge from the picked node to a node in use
// stalls the edge stream for the read-compare-write on the node RAM, which
// holds both distance and visited flag. The rounds stop early after a
// fruitless node sweep when no unvisited node of finite distance is left.
// A query whose source or target lies outside the nodes in use skips the
// search and answers unreachable. Configuration writes are always
// accepted and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module uniform_cost_shortest_path
  import ucsp_pkg::*;
#(
  parameter int unsigned MAX_NODES = MaxNodesDef,
  parameter int unsigned MAX_EDGES = MaxEdgesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // item input
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire ucsp_in_t            in_word_i,
  // result output
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output ucsp_out_t                out_word_o,
  // configuration writes
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_PICK,
    ST_ESCAN,
    ST_NODE_RD,
    ST_NODE_CHK,
    ST_RES_RD,
    ST_RES_CAP
  } state_e;

  state_e                state_q, state_d;
  logic [NodeCntW-1:0]   node_cnt_q, node_cnt_d;
  logic [EdgeCntW-1:0]   edge_cnt_q, edge_cnt_d;
  logic [NodeIdxW-1:0]   src_q, src_d;
  logic [NodeIdxW-1:0]   dst_q, dst_d;
  logic [CostW-1:0]      cost_q, cost_d;
  logic                  bad_q, bad_d;
  logic [NodeCntW-1:0]   idx_q, idx_d;
  logic                  pend_q, pend_d;
  logic [EdgeCntW-1:0]   eidx_q, eidx_d;
  logic [DistW-1:0]      best_q, best_d;
  logic [NodeCntW-1:0]   pick_q, pick_d;
  logic                  found_q, found_d;
  logic [NodeCntW-1:0]   round_q, round_d;
  logic [EndW-1:0]       tgt_q, tgt_d;
  logic                  out_valid_q, out_valid_d;
  ucsp_out_t             out_word_q, out_word_d;

  logic [NodeCntW-1:0]   n_eff;
  logic [EdgeCntW-1:0]   ne_eff;
  logic                  in_acc;
  logic                  cfg_acc;
  logic                  slot_ok;

  logic                  e_we;
  logic [EW-1:0]         e_waddr;
  ucsp_edge_t            e_wdata;
  logic [EW-1:0]         e_raddr;
  ucsp_edge_t            e_rdata;

  logic                  n_we;
  logic [NW-1:0]         n_waddr;
  ucsp_node_t            n_wdata;
  logic [NW-1:0]         n_raddr;
  ucsp_node_t            n_rdata;

  logic [DistW-1:0]      alu_lhs;
  logic [DistW-1:0]      alu_rhs;
  logic [DistW-1:0]      cand;
  logic                  less;
  logic                  edge_hit;
  logic [NodeCntW-1:0]   round_nx;

  // effective sizes, saturated to the store depths
  assign n_eff  = ({{(32 - NodeCntW){1'b0}}, node_cnt_q} > MAX_NODES)
                  ? NodeCntW'(MAX_NODES) : node_cnt_q;
  assign ne_eff = ({{(32 - EdgeCntW){1'b0}}, edge_cnt_q} > MAX_EDGES)
                  ? EdgeCntW'(MAX_EDGES) : edge_cnt_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // edge store: loads write, the relaxation pass streams it
  assign slot_ok = {{(32 - SlotW){1'b0}}, in_word_i.edge_slot} < MAX_EDGES;
  assign e_we    = in_acc && (in_word_i.command == CMD_LOAD) && slot_ok;
  assign e_waddr = EW'(in_word_i.edge_slot);
  assign e_wdata = '{from_node: in_word_i.edge_from, to_node: in_word_i.edge_to};
  assign e_raddr = EW'(eidx_q);

  ucsp_ram #(
    .WIDTH ($bits(ucsp_edge_t)),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  // node store read address
  always_comb begin
    case (state_q)
      ST_NODE_RD, ST_NODE_CHK: n_raddr = NW'(tgt_q);
      ST_RES_RD, ST_RES_CAP:   n_raddr = NW'(dst_q);
      default:                 n_raddr = NW'(idx_q);
    endcase
  end

  // shared compare operands: minimum search or relaxation
  always_comb begin
    if (state_q == ST_NODE_CHK) begin
      alu_lhs = cand;
      alu_rhs = n_rdata.node_dist;
    end else begin
      alu_lhs = n_rdata.node_dist;
      alu_rhs = best_q;
    end
  end

  ucsp_alu u_alu (
    .best_i (best_q),
    .cost_i (cost_q),
    .lhs_i  (alu_lhs),
    .rhs_i  (alu_rhs),
    .sum_o  (cand),
    .less_o (less)
  );

  // node store writes: clearing sweep, visit mark, relaxation
  always_comb begin
    n_we    = 1'b0;
    n_waddr = NW'(idx_q);
    n_wdata = '{visited: 1'b0, node_dist: DIST_INF};
    case (state_q)
      ST_CLEAR: begin
        n_we = 1'b1;
        if (idx_q == {1'b0, src_q}) begin
          n_wdata.node_dist = '0;
        end
      end
      ST_PICK: begin
        n_we    = found_q;
        n_waddr = NW'(pick_q);
        n_wdata = '{visited: 1'b1, node_dist: best_q};
      end
      ST_NODE_CHK: begin
        n_we    = !n_rdata.visited && less;
        n_waddr = NW'(tgt_q);
        n_wdata = '{visited: 1'b0, node_dist: cand};
      end
      default: ;
    endcase
  end

  ucsp_ram #(
    .WIDTH ($bits(ucsp_node_t)),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (n_wdata),
    .raddr_i (n_raddr),
    .rdata_o (n_rdata)
  );

  // edge leaves the picked node towards a node in use
  assign edge_hit = pend_q
                 && (e_rdata.from_node != '0) && (e_rdata.from_node <= n_eff)
                 && (e_rdata.to_node != '0) && (e_rdata.to_node <= n_eff)
                 && (e_rdata.from_node == pick_q + NodeCntW'(1));

  assign round_nx = round_q + NodeCntW'(1);

  // sequencer
  always_comb begin
    state_d     = state_q;
    node_cnt_d  = node_cnt_q;
    edge_cnt_d  = edge_cnt_q;
    src_d       = src_q;
    dst_d       = dst_q;
    cost_d      = cost_q;
    bad_d       = bad_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    eidx_d      = eidx_q;
    best_d      = best_q;
    pick_d      = pick_q;
    found_d     = found_q;
    round_d     = round_q;
    tgt_d       = tgt_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // configuration registers
    if (cfg_acc) begin
      case (cfg_index_i)
        CFG_NODE_COUNT: node_cnt_d = cfg_data_i[NodeCntW-1:0];
        CFG_EDGE_COUNT: edge_cnt_d = cfg_data_i[EdgeCntW-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_word_i.command == CMD_QUERY)) begin
          src_d  = in_word_i.source_node;
          dst_d  = in_word_i.target_node;
          cost_d = in_word_i.step_cost;
          idx_d  = '0;
          if (({1'b0, in_word_i.source_node} >= n_eff) ||
              ({1'b0, in_word_i.target_node} >= n_eff)) begin
            bad_d   = 1'b1;
            state_d = ST_RES_CAP;
          end else begin
            bad_d   = 1'b0;
            state_d = ST_CLEAR;
          end
        end
      end

      // sweep nodes in use to unreached, source to zero
      ST_CLEAR: begin
        idx_d = idx_q + NodeCntW'(1);
        if (idx_q + NodeCntW'(1) >= n_eff) begin
          round_d = NodeCntW'(1);
          idx_d   = '0;
          pend_d  = 1'b0;
          best_d  = DIST_INF;
          pick_d  = '0;
          found_d = 1'b0;
          state_d = (NodeCntW'(1) < n_eff) ? ST_SCAN : ST_RES_RD;
        end
      end

      // stream nodes, keep the first unvisited node of least distance
      ST_SCAN: begin
        if (pend_q && !n_rdata.visited && less) begin
          best_d  = n_rdata.node_dist;
          pick_d  = idx_q - NodeCntW'(1);
          found_d = 1'b1;
        end
        if (idx_q < n_eff) begin
          idx_d  = idx_q + NodeCntW'(1);
          pend_d = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = ST_PICK;
        end
      end

      // mark the pick visited, or stop when nothing is left
      ST_PICK: begin
        eidx_d  = '0;
        pend_d  = 1'b0;
        state_d = found_q ? ST_ESCAN : ST_RES_RD;
      end

      // stream edges; stall on each one leaving the pick
      ST_ESCAN: begin
        if (edge_hit) begin
          tgt_d   = e_rdata.to_node - EndW'(1);
          pend_d  = 1'b0;
          state_d = ST_NODE_RD;
        end else if (eidx_q < ne_eff) begin
          eidx_d = eidx_q + EdgeCntW'(1);
          pend_d = 1'b1;
        end else begin
          round_d = round_nx;
          idx_d   = '0;
          pend_d  = 1'b0;
          best_d  = DIST_INF;
          pick_d  = '0;
          found_d = 1'b0;
          state_d = (round_nx < n_eff) ? ST_SCAN : ST_RES_RD;
        end
      end

      ST_NODE_RD: state_d = ST_NODE_CHK;

      ST_NODE_CHK: state_d = ST_ESCAN;

      ST_RES_RD: state_d = ST_RES_CAP;

      // load the result word once the output register is free
      ST_RES_CAP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (bad_q) begin
            out_word_d = '{distance: DIST_INF, reachable: 1'b0};
          end else begin
            out_word_d = '{distance: n_rdata.node_dist,
                           reachable: (n_rdata.node_dist != DIST_INF)};
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      node_cnt_q  <= NodeCntW'(64);
      edge_cnt_q  <= '0;
      bad_q       <= 1'b0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      eidx_q      <= '0;
      found_q     <= 1'b0;
      round_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      node_cnt_q  <= node_cnt_d;
      edge_cnt_q  <= edge_cnt_d;
      bad_q       <= bad_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      eidx_q      <= eidx_d;
      found_q     <= found_d;
      round_q     <= round_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    dst_q      <= dst_d;
    cost_q     <= cost_d;
    best_q     <= best_d;
    pick_q     <= pick_d;
    tgt_q      <= tgt_d;
    out_word_q <= out_word_d;
  end

endmodule

`default_nettype wire

// ===== test/ucsp_answer_checker.sv =====
// ----------------------------------------------------------------------------
// ucsp_answer_checker
// Watches the word, result and register channels of the shortest path engine,
// keeps its own copy of the edge store and sizes, works out the answer to
// every accepted query and compares it field by field with the result words.
// ----------------------------------------------------------------------------
`default_nettype none

module ucsp_answer_checker
  import ucsp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_ready_i,
  input  wire ucsp_in_t            in_word_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_ready_i,
  input  wire ucsp_out_t           out_word_i,
  input  wire logic                cfg_valid_i,
  input  wire logic                cfg_ready_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output int                       fails_o,
  output int                       pending_o,
  output int                       answered_o,
  output int                       reached_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ReportMax = 10;

  // shadow of the engine state
  ucsp_edge_t  edge_mem [MaxEdgesDef];
  int unsigned nodes_cfg;
  int unsigned edges_cfg;

  // answers owed by the engine, oldest first
  ucsp_out_t   due_answers [$];

  int mismatches = 0;
  int answered   = 0;
  int reached    = 0;

  // dense Dijkstra over the shadow edge list, one step cost for every edge
  function automatic ucsp_out_t shortest_path(input logic [NodeIdxW-1:0] src,
                                              input logic [NodeIdxW-1:0] tgt,
                                              input logic [CostW-1:0]    cost);
    int unsigned      n, ne, best, pick, cand, tail_n, head_n;
    logic [DistW-1:0] node_dist [MaxNodesDef];
    bit               done [MaxNodesDef];
    bit               found;
    ucsp_out_t        res;
    n  = (nodes_cfg > MaxNodesDef) ? MaxNodesDef : nodes_cfg;
    ne = (edges_cfg > MaxEdgesDef) ? MaxEdgesDef : edges_cfg;
    for (int i = 0; i < MaxNodesDef; i++) begin
      node_dist[i] = DIST_INF;
      done[i] = 1'b0;
    end
    // source or target outside the nodes in use
    if (src >= n || tgt >= n) begin
      res.distance  = DIST_INF;
      res.reachable = 1'b0;
      return res;
    end
    node_dist[src] = '0;
    for (int r = 1; r + 1 <= n; r++) begin
      // lowest index among the least finite distances
      best  = DIST_INF;
      pick  = 0;
      found = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (!done[i] && node_dist[i] < best) begin
          best  = node_dist[i];
          pick  = i;
          found = 1'b1;
        end
      end
      if (!found) break;
      done[pick] = 1'b1;
      // relax edges leaving the picked node; zero or oversized ends never count
      for (int j = 0; j < ne; j++) begin
        tail_n = edge_mem[j].from_node;
        head_n = edge_mem[j].to_node;
        if (tail_n == 0 || tail_n > n || head_n == 0 || head_n > n) continue;
        if (tail_n - 1 != pick || done[head_n - 1]) continue;
        cand = best + cost;
        if (cand > DIST_SAT) cand = DIST_SAT;
        if (cand < node_dist[head_n - 1]) node_dist[head_n - 1] = DistW'(cand);
      end
    end
    res.distance  = node_dist[tgt];
    res.reachable = (node_dist[tgt] != DIST_INF);
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatches < ReportMax) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // follow every handshake at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    ucsp_out_t want;
    if (!rst_ni) begin
      nodes_cfg = MaxNodesDef;
      edges_cfg = 0;
      due_answers.delete();
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_NODE_COUNT: nodes_cfg = cfg_data_i[NodeCntW-1:0];
          CFG_EDGE_COUNT: edges_cfg = cfg_data_i[EdgeCntW-1:0];
          default: ;
        endcase
      end
      // accepted input word: store an edge or queue the answer of a query
      if (in_valid_i && in_ready_i) begin
        if (in_word_i.command == CMD_LOAD) begin
          edge_mem[in_word_i.edge_slot].from_node = in_word_i.edge_from;
          edge_mem[in_word_i.edge_slot].to_node   = in_word_i.edge_to;
        end else begin
          due_answers.push_back(shortest_path(in_word_i.source_node,
                                              in_word_i.target_node,
                                              in_word_i.step_cost));
        end
      end
      // accepted result word
      if (out_valid_i && out_ready_i) begin
        if (due_answers.size() == 0) begin
          note_mismatch($sformatf("result word with no query waiting: distance %0d reachable %0d",
                                  out_word_i.distance, out_word_i.reachable));
        end else begin
          want = due_answers.pop_front();
          answered++;
          if (want.reachable) reached++;
          if (out_word_i.distance !== want.distance)
            note_mismatch($sformatf("distance expected %0d, got %0d",
                                    want.distance, out_word_i.distance));
          if (out_word_i.reachable !== want.reachable)
            note_mismatch($sformatf("reachable expected %0d, got %0d",
                                    want.reachable, out_word_i.reachable));
        end
      end
    end
    pending_o  <= due_answers.size();
    fails_o    <= mismatches;
    answered_o <= answered;
    reached_o  <= reached;
  end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the uniform cost shortest path engine. A short
// directed part covers the size extremes and the corner queries, then the
// low part of the edge store is filled with a long chain and random edges
// and the engine is run through random phases of sizes, edge loads and
// queries, with random idling on both channels and one long output stall.
// Checking is done by ucsp_answer_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ucsp_pkg::*;

  localparam int ClkHalf     = 4;
  localparam int ResetCycles = 9;
  localparam int CycleLimit  = 10_000_000;
  localparam int SinkHold    = 3000;
  localparam int Settle      = 8;
  localparam int Tail        = 16;
  localparam int RandPhases  = 5;
  localparam int PhaseWords  = 6;
  localparam int FillSlots   = 48;
  localparam int ChainLen    = 31;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  ucsp_in_t            in_word   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ucsp_out_t           out_word;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = CFG_NODE_COUNT;
  logic [CfgDataW-1:0] cfg_data  = '0;

  int fails, pending, answered, reached;

  // stimulus bookkeeping
  int unsigned n_eff     = MaxNodesDef;
  int unsigned e_eff     = 0;
  int          loads     = 0;
  int          queries   = 0;
  int          hold_reqs = 0;
  bit          quiet     = 1'b0;
  bit          calm      = 1'b0;

  uniform_cost_shortest_path uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  ucsp_answer_checker answer_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_word_i  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fails_o     (fails),
    .pending_o   (pending),
    .answered_o  (answered),
    .reached_o   (reached)
  );

  initial begin : clock
    clk = 1'b0;
    forever #(ClkHalf) clk = ~clk;
  end

  // random field values; unused fields of a word stay random
  function automatic ucsp_in_t rand_word();
    logic [63:0] bits64;
    bits64 = {$urandom(), $urandom()};
    return bits64[$bits(ucsp_in_t)-1:0];
  endfunction

  function automatic int unsigned rand_end();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 127);
    return $urandom_range(1, (n_eff > 0) ? n_eff : 1);
  endfunction

  function automatic int unsigned rand_node();
    if (n_eff == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, 63);
    return $urandom_range(0, n_eff - 1);
  endfunction

  function automatic int unsigned rand_cost();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 16'hFFFF;
      2, 3:    return $urandom_range(1, 15);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // one word on the input channel, with an optional gap in front
  task automatic send_word(input ucsp_in_t w);
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    if (w.command == CMD_LOAD) loads++;
    else queries++;
  endtask

  task automatic load_edge(input int unsigned slot, tail_n, head_n);
    ucsp_in_t w;
    w           = rand_word();
    w.command   = CMD_LOAD;
    w.edge_slot = SlotW'(slot);
    w.edge_from = EndW'(tail_n);
    w.edge_to   = EndW'(head_n);
    send_word(w);
  endtask

  task automatic ask(input int unsigned src, tgt, cost);
    ucsp_in_t w;
    w             = rand_word();
    w.command     = CMD_QUERY;
    w.source_node = NodeIdxW'(src);
    w.target_node = NodeIdxW'(tgt);
    w.step_cost   = CostW'(cost);
    send_word(w);
  endtask

  // engine idle: all answers in, then a short pause for a trailing load
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgDataW'(data);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_sizes(input int unsigned node_data, edge_data);
    write_reg(CFG_NODE_COUNT, node_data);
    write_reg(CFG_EDGE_COUNT, edge_data);
    n_eff = node_data % 128;
    if (n_eff > MaxNodesDef) n_eff = MaxNodesDef;
    e_eff = edge_data % 512;
    if (e_eff > MaxEdgesDef) e_eff = MaxEdgesDef;
  endtask

  // result side: short random stalls, one long hold-off on request
  initial begin : sink
    int holds_done;
    holds_done = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (SinkHold) @(posedge clk);
      end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout: no verdict after %0d cycles", CycleLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned n_data, e_data, slot;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty edge list at full node count
    set_sizes(64, 0);
    ask(0, 0, 0);
    ask(63, 63, 16'hFFFF);
    ask(0, 63, 1);
    ask(5, 3, 100);
    // small graph with a shortcut, a zero end, oversized ends and a high slot
    load_edge(0, 1, 2);
    load_edge(1, 2, 3);
    load_edge(2, 1, 3);
    load_edge(3, 0, 2);
    load_edge(4, 3, 65);
    load_edge(5, 127, 1);
    load_edge(255, 64, 1);
    settle();
    set_sizes(3, 6);
    ask(0, 2, 7);
    ask(0, 1, 16'hFFFF);
    ask(2, 0, 5);
    ask(3, 0, 1);
    ask(0, 3, 1);
    // degenerate node counts
    settle();
    set_sizes(1, 6);
    ask(0, 0, 9);
    ask(0, 1, 9);
    settle();
    set_sizes(0, 6);
    ask(0, 0, 9);
    // node count above the store saturates
    settle();
    set_sizes(127, 6);
    ask(0, 2, 3);
    ask(2, 63, 1);

    // low part of the edge store: a long forward chain, random edges after
    settle();
    for (slot = 0; slot < FillSlots; slot++) begin
      if (slot < ChainLen) load_edge(slot, slot + 1, slot + 2);
      else load_edge(slot, rand_end(), rand_end());
    end
    // largest queries over every node in use
    settle();
    set_sizes(64, FillSlots);
    ask(0, ChainLen, 16'hFFFF);
    ask(0, 63, 1);
    ask(rand_node(), rand_node(), rand_cost());
    settle();
    set_sizes(64, ChainLen);
    ask(63, 0, 5);

    // random phases; mostly small graphs so that queries stay short
    for (int p = 0; p < RandPhases; p++) begin
      settle();
      quiet <= (p == 2);
      calm  <= (p == RandPhases - 1);
      if (p == 1) hold_reqs <= hold_reqs + 1;
      if (p == 0) n_data = 2;
      else if (p == 4) n_data = $urandom_range(65, 127) + 128 * $urandom_range(0, 3);
      else if (p != 1 && $urandom_range(0, 9) == 0) n_data = $urandom_range(0, 1);
      else if (p == 1 || $urandom_range(0, 3) != 0) n_data = $urandom_range(2, 12);
      else n_data = $urandom_range(13, 24);
      if (p == 4) e_data = $urandom_range(0, 40);
      else e_data = $urandom_range(0, FillSlots);
      set_sizes(n_data, e_data);
      // queries only under the long hold-off so that the engine backs up
      for (int k = 0; k < PhaseWords; k++) begin
        if (p != 1 && $urandom_range(0, 9) < 4) begin
          if (e_eff > 0 && $urandom_range(0, 4) != 0) slot = $urandom_range(0, e_eff - 1);
          else slot = $urandom_range(0, 255);
          load_edge(slot, rand_end(), rand_end());
        end else begin
          ask(rand_node(), rand_node(), rand_cost());
        end
      end
    end

    settle();
    repeat (Tail) @(posedge clk);
    $display("covered %0d edge loads and %0d queries; %0d answers checked, %0d reachable",
             loads, queries, answered, reached);
    $display("node counts 0 to 64 and above, edge counts 0 to %0d, %0d-cycle stall",
             FillSlots, SinkHold);
    if (fails == 0 && pending == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
